### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
// Requires clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold whenever out of reset.
`define CHK_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/fpaa_pkg.sv
// Package for the fractional PAA reducer: widths, types, register indexes.
// No dependencies.
package fpaa_pkg;
  localparam int MaxWindowDef   = 65536;
  localparam int MaxSegmentsDef = 1024;
  localparam int SumW = 44;
  localparam int PosMax = 131071;

  localparam logic [1:0] REG_START   = 2'd0;
  localparam logic [1:0] REG_WINDOW  = 2'd1;
  localparam logic [1:0] REG_SEGMENT = 2'd2;

  // Job handed from front to back.
  typedef struct packed {
    logic              divide;   // 1: segment mean, 0: pass-through
    logic signed [SumW-1:0] sum;
    logic [16:0]       x;
    logic signed [15:0] smp;
    logic [15:0]       idx;
    logic              last;
  } job_t;
endpackage

### hw/rtl/fpaa_front.sv
// Front end: row tracking, windowing and weighted accumulation.
// Depends on fpaa_pkg.
module fpaa_front import fpaa_pkg::*; #(
  parameter int MAX_WINDOW   = MaxWindowDef,
  parameter int MAX_SEGMENTS = MaxSegmentsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic signed [15:0] smp,
  input  logic               first,
  input  logic [15:0]        start_offset,
  input  logic [16:0]        window_len,
  input  logic [10:0]        segment_count,
  output logic               job_vld,
  output job_t               job
);
  logic [16:0] pos_r, pos_nxt, pos_cur, fill_r, fill_nxt, fill_cur;
  logic [15:0] seg_r, seg_nxt, seg_cur;
  logic signed [SumW-1:0] sum_r, sum_nxt, sum_cur;
  logic [16:0] x, l, w, take_w, rest;
  logic [17:0] fl;
  logic inwin;

  always_comb begin
    x = (window_len > 17'(MAX_WINDOW)) ? 17'(MAX_WINDOW) : window_len;
    l = {6'd0, segment_count};
    if (l == '0) l = 17'd1;
    if (l > 17'(MAX_SEGMENTS)) l = 17'(MAX_SEGMENTS);
    pos_cur  = first ? '0 : pos_r;
    seg_cur  = first ? '0 : seg_r;
    fill_cur = first ? '0 : fill_r;
    sum_cur  = first ? '0 : sum_r;
    w = pos_cur - {1'b0, start_offset};
    inwin = (x != '0) && (pos_cur >= {1'b0, start_offset}) && (w < x);
    fl = {1'b0, fill_cur} + {1'b0, l};
    take_w = (x > fill_cur) ? x - fill_cur : '0;
    if (take_w > l) take_w = l;
    rest = l - take_w;
    pos_nxt = (pos_cur != 17'(PosMax)) ? pos_cur + 17'd1 : pos_cur;
    seg_nxt = seg_cur; fill_nxt = fill_cur; sum_nxt = sum_cur;
    job_vld = 1'b0;
    job.divide = 1'b0; job.sum = '0; job.x = x; job.smp = smp;
    job.idx = w[15:0]; job.last = (w == x - 17'd1);
    if (inwin) begin
      if (x <= l) job_vld = 1'b1;
      else if (fl < {1'b0, x}) begin
        sum_nxt  = sum_cur + SumW'(smp) * $signed({1'b0, l});
        fill_nxt = fl[16:0];
      end else begin
        job_vld = 1'b1; job.divide = 1'b1;
        job.sum = sum_cur + SumW'(smp) * $signed({1'b0, take_w});
        job.idx = seg_cur;
        seg_nxt = (seg_cur != 16'hFFFF) ? seg_cur + 16'd1 : seg_cur;
        sum_nxt = SumW'(smp) * $signed({1'b0, rest});
        fill_nxt = rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; seg_r <= '0; fill_r <= '0; sum_r <= '0;
    end else if (take) begin
      pos_r <= pos_nxt; seg_r <= seg_nxt; fill_r <= fill_nxt; sum_r <= sum_nxt;
    end
  end
endmodule

### hw/rtl/fpaa_back.sv
// Back end: queue of jobs and a radix-2 restoring divider for the means.
// Depends on fpaa_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fpaa_back import fpaa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_vld,
  input  job_t               job,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] coefficient,
  output logic [15:0]        coeff_index,
  output logic               row_last
);
  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} st_t;
  localparam int MagW = SumW;

  job_t q_r [2];
  logic [1:0] cnt_r;
  logic       rd_r, wr_r;
  st_t        st_r;
  job_t       cur_r;
  logic       neg_r;
  logic [MagW-1:0] quo_r;
  logic [17:0] rem_r;
  logic [5:0]  bit_r;
  logic        pop, push;
  logic [18:0] trial;
  logic [MagW:0] qr;
  logic signed [MagW+1:0] v;
  logic signed [15:0] res;

  assign push = job_vld;
  assign pop  = (st_r == ST_IDLE) && (cnt_r != '0);
  assign full = (cnt_r == 2'd2);
  assign trial = {rem_r, quo_r[MagW-1]} - {2'b0, cur_r.x};

  always_comb begin
    qr = {1'b0, quo_r} + ((({rem_r, 1'b0}) >= {1'b0, cur_r.x}) ? 1'b1 : 1'b0);
    v = neg_r ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
    if (v > 32767) res = 16'sd32767;
    else if (v < -32768) res = -16'sd32768;
    else res = v[15:0];
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= job;
    if (!rst_n) begin
      cnt_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0; st_r <= ST_IDLE; out_valid <= 1'b0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
      case (st_r)
        ST_IDLE: if (pop) begin
          cur_r <= q_r[rd_r];
          neg_r <= q_r[rd_r].sum[SumW-1];
          quo_r <= q_r[rd_r].sum[SumW-1] ? MagW'(-q_r[rd_r].sum) : MagW'(q_r[rd_r].sum);
          rem_r <= '0; bit_r <= '0;
          st_r  <= q_r[rd_r].divide ? ST_DIV : ST_OUT;
          if (!q_r[rd_r].divide) begin
            coefficient <= q_r[rd_r].smp; coeff_index <= q_r[rd_r].idx;
            row_last <= q_r[rd_r].last; out_valid <= 1'b1;
          end
        end
        ST_DIV: begin
          if (!trial[18]) begin
            rem_r <= trial[17:0]; quo_r <= {quo_r[MagW-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[16:0], quo_r[MagW-1]}; quo_r <= {quo_r[MagW-2:0], 1'b0};
          end
          bit_r <= bit_r + 6'd1;
          if (bit_r == 6'(MagW-1)) st_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid) begin
            coefficient <= res; coeff_index <= cur_r.idx;
            row_last <= cur_r.last; out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0; st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  `CHK_ALWAYS(a_no_overflow, !(full && push), "job queue overflow")
  `CHK_NEXT(a_div_len, (st_r == ST_DIV) && (bit_r != 6'(MagW-1)), st_r == ST_DIV, "divider quit early")
  `CHK_ALWAYS(a_out_state, !out_valid || st_r == ST_OUT, "result shown outside output state")
endmodule

### hw/rtl/fractional_paa_reducer.sv
// Fractional PAA reducer: top level, config registers, front and back ends.
// Depends on fpaa_pkg, fpaa_front, fpaa_back.
// Pass-through: pop, then show; segment mean: pop, 44-bit divide, then show.
// The back end works on one job at a time, popping the next only when idle;
// samples flow at one per cycle until the two-entry job queue fills, then stall.
// Reset: synchronous active-low; registers 0/1024/16, row state cleared.
module fractional_paa_reducer import fpaa_pkg::*; #(
  parameter int MAX_WINDOW   = MaxWindowDef,
  parameter int MAX_SEGMENTS = MaxSegmentsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample,
  input  logic               in_row_first,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_coefficient,
  output logic [15:0]        out_coeff_index,
  output logic               out_row_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data
);
  logic [15:0] start_r;
  logic [16:0] window_r;
  logic [10:0] segs_r;
  logic        full, take, jv;
  job_t        job;

  assign cfg_ready = 1'b1;
  // any item, windowed or not, waits while the queue is full
  assign in_stall = full;
  assign take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0; window_r <= 17'd1024; segs_r <= 11'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START:   start_r  <= cfg_data[15:0];
        REG_WINDOW:  window_r <= cfg_data;
        REG_SEGMENT: segs_r   <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  fpaa_front #(.MAX_WINDOW(MAX_WINDOW), .MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
    .clk, .rst_n, .take, .smp(in_sample), .first(in_row_first),
    .start_offset(start_r), .window_len(window_r), .segment_count(segs_r),
    .job_vld(jv), .job
  );

  fpaa_back u_back (
    .clk, .rst_n, .job_vld(jv && take), .job, .full,
    .out_valid, .out_stall, .coefficient(out_coefficient),
    .coeff_index(out_coeff_index), .row_last(out_row_last)
  );
endmodule

### bench/fpaa_checker.sv
// Checker for the fractional PAA reducer: watches the sample, coefficient and
// register channels, predicts each coefficient and compares. Needs fpaa_pkg.
`timescale 1ns / 100ps

module fpaa_checker import fpaa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_sample,
  input  logic               in_row_first,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_coefficient,
  input  logic [15:0]        out_coeff_index,
  input  logic               out_row_last,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  output int                 mismatches,
  output int                 outstanding,
  output int                 coeffs_seen
);

  typedef struct packed {
    logic signed [15:0] coef;
    logic [15:0]        idx;
    logic               last;
  } coeff_t;

  coeff_t due_coeffs[$];

  // register copies and row state
  logic [15:0] start_q;
  logic [16:0] window_q;
  logic [10:0] segs_q;
  int unsigned position, seg_no, fill;
  longint      seg_sum;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t checker: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic add_due(logic signed [15:0] coef, logic [15:0] idx, logic lst);
    coeff_t c;
    c.coef = coef;
    c.idx = idx;
    c.last = lst;
    due_coeffs = {due_coeffs, c};
  endtask

  function automatic logic signed [15:0] segment_mean(longint sum, int unsigned x);
    longint mag, q, r, v;
    mag = (sum < 0) ? -sum : sum;
    q = mag / x;
    r = mag % x;
    if (2 * r >= x) q++;
    if (q > 40000) q = 40000;
    v = (sum < 0) ? -q : q;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic take_sample(logic signed [15:0] s, logic rf);
    int unsigned x, l, p, w, take, rest;
    logic lastw;
    x = window_q;
    if (x > MaxWindowDef) x = MaxWindowDef;
    l = segs_q;
    if (l == 0) l = 1;
    if (l > MaxSegmentsDef) l = MaxSegmentsDef;
    if (rf) begin
      position = 0; seg_no = 0; fill = 0; seg_sum = 0;
    end
    p = position;
    if (position < PosMax) position++;
    if (x == 0 || p < start_q) return;
    w = p - start_q;
    if (w >= x) return;
    lastw = (w == x - 1);
    if (x <= l) begin
      add_due(s, w[15:0], lastw);
    end else if (fill + l < x) begin
      seg_sum += longint'(s) * longint'(l);
      fill += l;
    end else begin
      take = (x > fill) ? x - fill : 0;
      if (take > l) take = l;
      rest = l - take;
      seg_sum += longint'(s) * longint'(take);
      add_due(segment_mean(seg_sum, x), seg_no[15:0], lastw);
      if (seg_no < 65535) seg_no++;
      seg_sum = longint'(s) * longint'(rest);
      fill = rest;
    end
  endtask

  always @(posedge clk) begin
    coeff_t want;
    if (!rst_n) begin
      start_q <= 16'd0; window_q <= 17'd1024; segs_q <= 11'd16;
      position = 0; seg_no = 0; fill = 0; seg_sum = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START:   start_q  <= cfg_data[15:0];
          REG_WINDOW:  window_q <= cfg_data;
          REG_SEGMENT: segs_q   <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_sample(in_sample, in_row_first);
      if (out_valid && !out_stall) begin
        coeffs_seen++;
        if (due_coeffs.size() == 0) begin
          report("unexpected coefficient", out_coefficient, 0);
        end else begin
          want = due_coeffs.pop_front();
          if (out_coefficient !== want.coef) report("coefficient", out_coefficient, want.coef);
          if (out_coeff_index !== want.idx) report("coeff_index", out_coeff_index, want.idx);
          if (out_row_last !== want.last) report("row_last", out_row_last, want.last);
        end
      end
    end
    outstanding = due_coeffs.size();
  end

  initial begin
    mismatches = 0;
    outstanding = 0;
    coeffs_seen = 0;
  end

endmodule

### bench/tb.sv
// Testbench top for the fractional PAA reducer: clock, reset, sample and
// register stimulus, verdict. Needs fpaa_pkg, fpaa_checker and the RTL.
`timescale 1ns / 100ps

module tb;
  import fpaa_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_sample = '0;
  logic               in_row_first = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_coefficient;
  logic [15:0]        out_coeff_index;
  logic               out_row_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = REG_START;
  logic [16:0]        cfg_data = '0;

  int mismatches, outstanding, coeffs_seen;
  int items_sent = 0;
  int phases = 0;
  bit quiet = 1'b0;   // no idling on either side in the closing stretch

  fractional_paa_reducer DUT (.*);

  fpaa_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure: random stall and run bursts; a stall burst is always followed by a run
  int  stall_left = 0;
  bit  stalling = 1'b0;
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stalling = ($urandom_range(0, 2) == 0) ? !stalling : 1'b0;
      out_stall <= stalling;
      stall_left <= $urandom_range(1, 18);
    end
  end

  // one sample item, held until accepted; random gaps in front of it
  task automatic push(logic signed [15:0] s, logic rf);
    bit acc;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_row_first <= rf;
    do begin
      @(negedge clk);
      acc = !in_stall;
      @(posedge clk);
    end while (!acc);
    items_sent++;
  endtask

  task automatic rest_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    bit acc;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      acc = cfg_ready;
      @(posedge clk);
    end while (!acc);
  endtask

  // the divider may still hold a mean that no item is waiting on, so after
  // the last expected coefficient allow the divider's latency to run out
  task automatic drain();
    rest_valid();
    while (outstanding != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic configure(int unsigned st, int unsigned win, int unsigned seg);
    drain();
    write_reg(REG_START, st[16:0]);
    write_reg(REG_WINDOW, win[16:0]);
    write_reg(REG_SEGMENT, seg[16:0]);
    cfg_valid <= 1'b0;
    phases++;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_row(int unsigned len, bit fresh);
    for (int unsigned i = 0; i < len; i++) push(pick_sample(), fresh && i == 0);
  endtask

  initial begin
    int unsigned st, win, seg, rows, len;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no row flag seen yet: stream counts as inside a row (default setting)
    push(16'sh7fff, 1'b0);
    push(16'sh8000, 1'b0);
    push(16'sh0001, 1'b0);

    // zero window selects nothing
    configure(0, 0, 4);
    push(16'sh1234, 1'b1);
    push(16'sh4321, 1'b0);

    // pass-through with extremes
    configure(0, 3, 16);
    push(16'sh7fff, 1'b1);
    push(16'sh8000, 1'b0);
    push(16'sh0000, 1'b0);

    // fractional split behind an offset
    configure(1, 5, 2);
    push(16'sh0100, 1'b1);
    push(16'sh7fff, 1'b0);
    push(16'sh7fff, 1'b0);
    push(16'sh8000, 1'b0);
    push(16'sh8000, 1'b0);
    push(16'shffff, 1'b0);
    push(16'sh0055, 1'b0);

    // oversized window and segment count get clamped
    configure(3, 131071, 2047);
    repeat (4) push(pick_sample(), 1'b0);

    // zero segments acts as one
    configure(0, 4, 0);
    send_row(5, 1'b1);

    // largest offset: nothing reached in a short row
    configure(65535, 3, 2);
    send_row(3, 1'b1);

    // change mid-row with fill already at the new window: closing weight zero
    configure(0, 10, 4);
    send_row(4, 1'b1);
    configure(0, 6, 4);
    push(16'sh2000, 1'b0);
    push(16'sh8000, 1'b0);

    // random phases of rows, mostly well-formed
    while (items_sent < 1900) begin
      st  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 100) : $urandom_range(0, 4);
      win = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 300) : $urandom_range(1, 32);
      case ($urandom_range(0, 11))
        0: seg = 0;
        1: seg = 1024;
        2: seg = 2047;
        default: seg = $urandom_range(1, 12);
      endcase
      if (items_sent > 1700) quiet = 1'b1;
      configure(st, win, seg);
      rows = $urandom_range(1, 4);
      for (int r = 0; r < rows; r++) begin
        len = st + win + $urandom_range(0, 2);
        if ($urandom_range(0, 5) == 0) len = $urandom_range(1, len);
        send_row(len, !(r == 0 && $urandom_range(0, 5) == 0));
      end
    end

    drain();
    $display("tb: %0d samples over %0d register settings, %0d coefficients checked",
             items_sent, phases, coeffs_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // hard stop
  initial begin
    #20000000;
    $display("tb: timed out");
    $display("tb: done, errors");
    $finish;
  end

endmodule
